>>> sv/loop_current_average_timed_alarm_assert.svh
`ifndef LOOP_CURRENT_AVERAGE_TIMED_ALARM_ASSERT_SVH
`define LOOP_CURRENT_AVERAGE_TIMED_ALARM_ASSERT_SVH

// Same-cycle implication on the module's clock, off while reset is high.
`define LCATA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on the module's clock, off while reset is high.
`define LCATA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lcata_pkg.sv
package lcata_pkg;

   // Window geometry and the widths that follow from it.
   localparam int WINDOW    = 8;
   localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int NUM_W     = $clog2(WINDOW + 1);
   localparam int UA_W      = 16;
   localparam int SUM_W     = $clog2(WINDOW * 65535 + 1);
   localparam int CODE_W    = 15;
   localparam int Q16_W     = 20;
   localparam int MUL_A_W   = 32;
   localparam int MUL_B_W   = (SUM_W > Q16_W) ? SUM_W : Q16_W;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int DIV_W     = SUM_W + 16;
   localparam int DIV_STEPS = (DIV_W + 1) / 2;
   localparam int DIV_PAD_W = 2 * DIV_STEPS;
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int REM_W     = $clog2(2 * WINDOW);

   localparam int LOOP_ZERO_UA = 4000;
   localparam int PRES_MAX     = 32767;
   localparam int PRES_MIN     = -32768;

   // Configuration port.
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_MAX_CODE  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_UA_Q16    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LOOP_BRK  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CAL_OFS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CAL_SCALE = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ALARM_THR = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_HOLD_MS   = 3'd6;

   // Operation codes.
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_CHECK  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] adc_code;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic [15:0]        current_ua;
      logic               current_valid;
      logic [15:0]        average_ua;
      logic               average_valid;
      logic signed [15:0] pressure_pa;
      logic               sensor_ok;
      logic               alarm_latched;
   } rsp_type;

   typedef struct packed {
      logic [14:0]        max_code;
      logic [19:0]        ua_per_code_q16;
      logic [14:0]        loop_break_ua;
      logic signed [15:0] cal_offset_pa;
      logic signed [31:0] cal_scale_q16;
      logic signed [15:0] alarm_threshold_pa;
      logic [31:0]        alarm_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [NUM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> sv/lcata_div.sv
`include "loop_current_average_timed_alarm_assert.svh"

module lcata_div import lcata_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    count_ff, count_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [REM_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_PAD_W-1:0] quo_ff, quo_in;

   logic [REM_W:0] r1, r1_sub, r2, r2_sub;
   logic           q1, q2;

   // Two restoring steps per cycle: the dividend shifts out at the top while
   // quotient bits enter at the bottom.
   always_comb begin
      r1     = {rem_ff, quo_ff[DIV_PAD_W-1]};
      q1     = (r1 >= (REM_W+1)'(dsr_ff));
      r1_sub = q1 ? (r1 - (REM_W+1)'(dsr_ff)) : r1;
      r2     = {r1_sub[REM_W-1:0], quo_ff[DIV_PAD_W-2]};
      q2     = (r2 >= (REM_W+1)'(dsr_ff));
      r2_sub = q2 ? (r2 - (REM_W+1)'(dsr_ff)) : r2;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;

      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dsr_in   = REM_W'(div_req.divisor);
         quo_in   = DIV_PAD_W'(div_req.dividend);
      end else if (busy_ff) begin
         rem_in   = r2_sub[REM_W-1:0];
         quo_in   = {quo_ff[DIV_PAD_W-3:0], q1, q2};
         count_in = count_ff + STEP_W'(1);
         if (count_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[DIV_W-1:0];

   `LCATA_ASSERT_NOW(a_div_no_restart, div_req.start, !busy_ff, "divider restarted while busy")
   `LCATA_ASSERT_NOW(a_div_count_range, busy_ff, count_ff <= STEP_W'(DIV_STEPS - 1),
      "divider step count out of range")

endmodule

>>> sv/lcata_mul.sv
module lcata_mul import lcata_pkg::*; (
   input  logic                 clock,
   input  logic [MUL_A_W-1:0]   mul_a,
   input  logic [MUL_B_W-1:0]   mul_b,
   output logic [PROD_W-1:0]    prod
);

   logic [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> sv/lcata_csr.sv
module lcata_csr import lcata_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   localparam cfg_type CFG_RESET = '{
      max_code:           15'd32767,
      ua_per_code_q16:    20'd49648,
      loop_break_ua:      15'd3500,
      cal_offset_pa:      16'sd0,
      cal_scale_q16:      32'sd65536,
      alarm_threshold_pa: 16'sd200,
      alarm_hold_ms:      32'd60000
   };

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MAX_CODE:  cfg_in.max_code           = csr_pwdata[14:0];
            REG_UA_Q16:    cfg_in.ua_per_code_q16    = csr_pwdata[19:0];
            REG_LOOP_BRK:  cfg_in.loop_break_ua      = csr_pwdata[14:0];
            REG_CAL_OFS:   cfg_in.cal_offset_pa      = signed'(csr_pwdata[15:0]);
            REG_CAL_SCALE: cfg_in.cal_scale_q16      = signed'(csr_pwdata);
            REG_ALARM_THR: cfg_in.alarm_threshold_pa = signed'(csr_pwdata[15:0]);
            REG_HOLD_MS:   cfg_in.alarm_hold_ms      = csr_pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MAX_CODE:  csr_prdata = 32'(cfg_ff.max_code);
         REG_UA_Q16:    csr_prdata = 32'(cfg_ff.ua_per_code_q16);
         REG_LOOP_BRK:  csr_prdata = 32'(cfg_ff.loop_break_ua);
         REG_CAL_OFS:   csr_prdata = 32'(cfg_ff.cal_offset_pa);
         REG_CAL_SCALE: csr_prdata = 32'(cfg_ff.cal_scale_q16);
         REG_ALARM_THR: csr_prdata = 32'(cfg_ff.alarm_threshold_pa);
         REG_HOLD_MS:   csr_prdata = cfg_ff.alarm_hold_ms;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/loop_current_average_timed_alarm.sv
// Loop-current front end with a moving-average window and a timed alarm.
// req channel (valid/ready) carries one operation: sample, alarm check or
// alarm clear. Each accepted item yields exactly one transfer on the rsp
// channel with the latest current, the window mean, the calibrated pressure,
// the sensor status and the alarm latch.
// The csr port is an APB-style register file; pready is always high. Write
// registers only while no item is in flight.
// From acceptance to rsp_valid, nearly all of the time goes to two passes
// through the shared radix-4 divider (18 steps each): one for the mean, one
// for the pressure. Neither pass runs when the window is empty or holds an
// invalid entry.
// One item is in the block at a time; req_ready is high once the previous
// result sits in the output register, so an item may be accepted while that
// result still waits. A stalled rsp channel holds the finished result and
// the next result waits in the block until the register frees up.
// Reset clears the window, the alarm state and the registers to defaults.
`include "loop_current_average_timed_alarm_assert.svh"

module loop_current_average_timed_alarm import lcata_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_CUR,
      ST_UPDATE,
      ST_EVAL,
      ST_DIV_AVG,
      ST_MUL_P,
      ST_P_START,
      ST_DIV_P,
      ST_PRES,
      ST_ALARM
   } state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;

   // Sequencer and output register.
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   // Current item.
   logic [1:0]         op_ff, op_in;
   logic signed [15:0] code_ff, code_in;
   logic [31:0]        now_ff, now_in;

   // Window state.
   logic [UA_W-1:0]  ring_ff [WINDOW];
   logic [WINDOW-1:0] inv_ff, inv_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             filled_ff, filled_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [NUM_W-1:0] inv_cnt_ff, inv_cnt_in;
   logic [UA_W-1:0]  last_cur_ff, last_cur_in;
   logic             last_valid_ff, last_valid_in;

   // Alarm state.
   logic        alarm_pending_ff, alarm_pending_in;
   logic [31:0] alarm_start_ff, alarm_start_in;
   logic        alarm_latch_ff, alarm_latch_in;

   // Per-item intermediate results.
   logic               avg_ok_ff, avg_ok_in;
   logic [UA_W-1:0]    avg_ff, avg_in;
   logic signed [15:0] pres_ff, pres_in;
   logic [SUM_W-1:0]   diff_mag_ff, diff_mag_in;
   logic               diff_neg_ff, diff_neg_in;

   // Combinational helpers.
   logic                  code_ok;
   logic [PROD_W:0]       ua_rnd;
   logic [UA_W-1:0]       ua_new;
   logic [UA_W-1:0]       ua_old;
   logic                  inv_old;
   logic [NUM_W-1:0]      n_cur;
   logic signed [SUM_W:0] diff;
   logic [31:0]           scale_mag;
   logic [PROD_W:0]       p_rnd;
   logic                  pres_neg;
   logic signed [DIV_W+1:0] q_signed;
   logic signed [DIV_W+1:0] q_total;
   logic                  sensor_ok;
   logic                  exceed;
   logic [31:0]           elapsed;
   logic                  out_free;

   lcata_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lcata_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   lcata_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign code_ok = !code_ff[15] && (code_ff[CODE_W-1:0] <= cfg.max_code);
   assign n_cur   = filled_ff ? NUM_W'(WINDOW) : NUM_W'(wr_idx_ff);

   assign scale_mag = cfg.cal_scale_q16[31] ? 32'(-cfg.cal_scale_q16)
                                            : 32'(cfg.cal_scale_q16);

   // The multiplier serves the code scaling first and the pressure slope later.
   assign mul_a = (state_ff == ST_MUL_CUR) ? MUL_A_W'(code_ff[CODE_W-1:0]) : scale_mag;
   assign mul_b = (state_ff == ST_MUL_CUR) ? MUL_B_W'(cfg.ua_per_code_q16)
                                           : MUL_B_W'(diff_mag_ff);

   assign ua_rnd  = {1'b0, prod} + (PROD_W+1)'(32768);
   assign ua_new  = !code_ok ? '0 :
                    (|ua_rnd[PROD_W:32]) ? {UA_W{1'b1}} : ua_rnd[31:16];
   assign ua_old  = filled_ff ? ring_ff[wr_idx_ff] : '0;
   assign inv_old = filled_ff && inv_ff[wr_idx_ff];

   assign diff = signed'({1'b0, sum_ff})
               - signed'((SUM_W+1)'(n_cur) * (SUM_W+1)'(LOOP_ZERO_UA));

   // Half-away rounding of |num| / (n * 65536): add n * 32768, drop 16 bits,
   // and let the divider finish with n.
   assign p_rnd = {1'b0, prod} + ((PROD_W+1)'(n_cur) << 15);

   assign pres_neg = cfg.cal_scale_q16[31] ^ diff_neg_ff;
   assign q_signed = pres_neg ? -signed'({2'b00, div_rsp.quotient})
                              : signed'({2'b00, div_rsp.quotient});
   assign q_total  = q_signed + (DIV_W+2)'(cfg.cal_offset_pa);

   assign sensor_ok = last_valid_ff && (last_cur_ff >= UA_W'(cfg.loop_break_ua));
   assign exceed    = avg_ok_ff && (pres_ff > cfg.alarm_threshold_pa);
   assign elapsed   = now_ff - (alarm_pending_ff ? alarm_start_ff : now_ff);

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;
      op_in            = op_ff;
      code_in          = code_ff;
      now_in           = now_ff;
      inv_in           = inv_ff;
      wr_idx_in        = wr_idx_ff;
      filled_in        = filled_ff;
      sum_in           = sum_ff;
      inv_cnt_in       = inv_cnt_ff;
      last_cur_in      = last_cur_ff;
      last_valid_in    = last_valid_ff;
      alarm_pending_in = alarm_pending_ff;
      alarm_start_in   = alarm_start_ff;
      alarm_latch_in   = alarm_latch_ff;
      avg_ok_in        = avg_ok_ff;
      avg_in           = avg_ff;
      pres_in          = pres_ff;
      diff_mag_in      = diff_mag_ff;
      diff_neg_in      = diff_neg_ff;
      div_req.start    = 1'b0;
      div_req.dividend = p_rnd[DIV_W+15:16];
      div_req.divisor  = n_cur;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               code_in  = req_data.adc_code;
               now_in   = req_data.now_ms;
               state_in = (req_data.operation == OP_SAMPLE) ? ST_MUL_CUR : ST_EVAL;
            end
         end
         ST_MUL_CUR: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            sum_in         = sum_ff - SUM_W'(ua_old) + SUM_W'(ua_new);
            inv_cnt_in     = inv_cnt_ff - NUM_W'(inv_old) + NUM_W'(!code_ok);
            inv_in[wr_idx_ff] = !code_ok;
            if (wr_idx_ff == IDX_W'(WINDOW - 1)) begin
               wr_idx_in = '0;
               filled_in = 1'b1;
            end else begin
               wr_idx_in = wr_idx_ff + IDX_W'(1);
            end
            last_cur_in   = ua_new;
            last_valid_in = code_ok;
            state_in      = ST_EVAL;
         end
         ST_EVAL: begin
            diff_neg_in = diff[SUM_W];
            diff_mag_in = diff[SUM_W] ? SUM_W'(-diff) : SUM_W'(diff);
            avg_in      = '0;
            pres_in     = '0;
            if ((n_cur != '0) && (inv_cnt_ff == '0)) begin
               avg_ok_in        = 1'b1;
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(sum_ff) + DIV_W'(n_cur >> 1);
               state_in         = ST_DIV_AVG;
            end else begin
               avg_ok_in = 1'b0;
               state_in  = ST_ALARM;
            end
         end
         ST_DIV_AVG: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[UA_W-1:0];
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            state_in = ST_P_START;
         end
         ST_P_START: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_P;
         end
         ST_DIV_P: begin
            if (div_rsp.done) begin
               state_in = ST_PRES;
            end
         end
         ST_PRES: begin
            if (q_total > PRES_MAX) begin
               pres_in = 16'sh7FFF;
            end else if (q_total < PRES_MIN) begin
               pres_in = -16'sh8000;
            end else begin
               pres_in = q_total[15:0];
            end
            state_in = ST_ALARM;
         end
         ST_ALARM: begin
            if (out_free) begin
               if (op_ff == OP_CHECK) begin
                  if (!sensor_ok) begin
                     alarm_latch_in   = 1'b0;
                     alarm_pending_in = 1'b0;
                     alarm_start_in   = '0;
                  end else if (exceed) begin
                     alarm_pending_in = 1'b1;
                     if (!alarm_pending_ff) begin
                        alarm_start_in = now_ff;
                     end
                     if (elapsed >= cfg.alarm_hold_ms) begin
                        alarm_latch_in = 1'b1;
                     end
                  end else begin
                     alarm_pending_in = 1'b0;
                     alarm_start_in   = '0;
                  end
               end else if (op_ff == OP_CLEAR) begin
                  alarm_latch_in   = 1'b0;
                  alarm_pending_in = 1'b0;
                  alarm_start_in   = '0;
               end
               rsp_data_in.current_ua    = last_cur_ff;
               rsp_data_in.current_valid = last_valid_ff;
               rsp_data_in.average_ua    = avg_ff;
               rsp_data_in.average_valid = avg_ok_ff;
               rsp_data_in.pressure_pa   = pres_ff;
               rsp_data_in.sensor_ok     = sensor_ok;
               rsp_data_in.alarm_latched = alarm_latch_in;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff            <= OP_SAMPLE;
         inv_ff           <= '0;
         wr_idx_ff        <= '0;
         filled_ff        <= 1'b0;
         sum_ff           <= '0;
         inv_cnt_ff       <= '0;
         last_cur_ff      <= '0;
         last_valid_ff    <= 1'b0;
         alarm_pending_ff <= 1'b0;
         alarm_start_ff   <= '0;
         alarm_latch_ff   <= 1'b0;
      end else begin
         op_ff            <= op_in;
         inv_ff           <= inv_in;
         wr_idx_ff        <= wr_idx_in;
         filled_ff        <= filled_in;
         sum_ff           <= sum_in;
         inv_cnt_ff       <= inv_cnt_in;
         last_cur_ff      <= last_cur_in;
         last_valid_ff    <= last_valid_in;
         alarm_pending_ff <= alarm_pending_in;
         alarm_start_ff   <= alarm_start_in;
         alarm_latch_ff   <= alarm_latch_in;
      end
      code_ff     <= code_in;
      now_ff      <= now_in;
      avg_ok_ff   <= avg_ok_in;
      avg_ff      <= avg_in;
      pres_ff     <= pres_in;
      diff_mag_ff <= diff_mag_in;
      diff_neg_ff <= diff_neg_in;
   end

   // Sample ring; entries are only read back once the window has filled.
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         ring_ff[wr_idx_ff] <= ua_new;
      end
   end

   `LCATA_ASSERT_NOW(a_inv_count_match, 1'b1, inv_cnt_ff == NUM_W'($countones(inv_ff)),
      "invalid entry count disagrees with the invalid flags")
   `LCATA_ASSERT_NOW(a_div_done_expected, div_rsp.done,
      (state_ff == ST_DIV_AVG) || (state_ff == ST_DIV_P),
      "divider finished outside a divide state")
   `LCATA_ASSERT_NEXT(a_latch_only_on_check, !alarm_latch_ff && (op_ff != OP_CHECK),
      !alarm_latch_ff, "alarm latched without a check operation")

endmodule

>>> tb/sv/tb_loop_current_average_timed_alarm.sv
module tb_loop_current_average_timed_alarm;
   import lcata_pkg::*;

   localparam int N_REGS         = 7;
   localparam int N_STEPS        = 24;
   localparam int N_PHASES       = 13;
   localparam int PHASE_ITEMS    = 105;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [1:0]           OP_UNUSED  = 2'd3;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   loop_current_average_timed_alarm dut (.*);

   // Local copy of the block's registers and window state.
   cfg_type     loop_cfg;
   logic [15:0] ring [WINDOW];
   bit          ring_bad [WINDOW];
   int          wr_idx    = 0;
   bit          filled    = 1'b0;
   longint      win_sum   = 0;
   int          bad_count = 0;
   logic [15:0] last_ua   = '0;
   bit          last_ok   = 1'b0;
   bit          pending   = 1'b0;
   logic [31:0] start_ms  = '0;
   bit          latched   = 1'b0;

   rsp_type     readings_due [$];
   int          fault_count = 0;
   int          stall_left  = 0;
   int          idle_cycles = 0;
   bit          quiet       = 1'b0;
   bit          hold_off_request = 1'b0;
   logic [31:0] tick_ms;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type reading;
   } plan_row;

   // Rows with fixed set carry a reading that follows directly from reset state.
   plan_row directed_plan [N_STEPS] = '{
      '{'{OP_CHECK,  16'sd0,     32'd0},         1'b1, '0},
      '{'{OP_UNUSED, 16'sh7FFF,  32'hFFFF_FFFF}, 1'b1, '0},
      '{'{OP_CLEAR,  16'shFFFF,  32'd0},         1'b1, '0},
      '{'{OP_SAMPLE, 16'sh8000,  32'd0},         1'b1, '0},
      '{'{OP_SAMPLE, 16'sd0,     32'hFFFF_FFFF}, 1'b1,
        '{16'd0, 1'b1, 16'd0, 1'b0, 16'sd0, 1'b0, 1'b0}},
      '{'{OP_SAMPLE, 16'sh7FFF,  32'd0},         1'b0, '0},
      '{'{OP_CHECK,  16'sd0,     32'd5},         1'b0, '0},
      '{'{OP_SAMPLE, 16'sd20000, 32'd7},         1'b0, '0},
      '{'{OP_SAMPLE, 16'sd20000, 32'd8},         1'b0, '0},
      '{'{OP_SAMPLE, 16'sd20000, 32'd9},         1'b0, '0},
      '{'{OP_SAMPLE, 16'sd20000, 32'd10},        1'b0, '0},
      '{'{OP_SAMPLE, 16'sd20000, 32'd11},        1'b0, '0},
      '{'{OP_SAMPLE, 16'sd20000, 32'd12},        1'b0, '0},
      '{'{OP_CHECK,  16'sd0,     32'd1000},      1'b0, '0},
      '{'{OP_CHECK,  16'sd0,     32'd60999},     1'b0, '0},
      '{'{OP_CHECK,  16'sd0,     32'd61000},     1'b0, '0},
      '{'{OP_SAMPLE, 16'sd1,     32'd0},         1'b0, '0},
      '{'{OP_CHECK,  16'sd0,     32'd62000},     1'b0, '0},
      '{'{OP_SAMPLE, 16'sd20000, 32'd0},         1'b0, '0},
      '{'{OP_CHECK,  16'sd0,     32'hFFFF_FF00}, 1'b0, '0},
      '{'{OP_CHECK,  16'sd0,     32'h0000_EA00}, 1'b0, '0},
      '{'{OP_CLEAR,  16'sd0,     32'd0},         1'b0, '0},
      '{'{OP_SAMPLE, 16'sh7FFF,  32'hAAAA_5555}, 1'b0, '0},
      '{'{OP_CHECK,  16'sh8000,  32'h5555_AAAA}, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // Advances the window and alarm state by one operation and returns the reading.
   function automatic rsp_type predict_reading(input req_type item);
      longint      code, ua, fill, avg, num, den, pres;
      bit          code_ok, mean_ok, loop_ok;
      logic [31:0] held;
      rsp_type     reading;
      if (item.operation == OP_SAMPLE) begin
         code = longint'(item.adc_code);
         code_ok = (code >= 0) && (code <= longint'(loop_cfg.max_code));
         ua = 0;
         if (code_ok) begin
            ua = (code * longint'(loop_cfg.ua_per_code_q16) + 64'sd32768) >>> 16;
            if (ua > 65535) ua = 65535;
         end
         // The oldest entry only leaves the sum once the window has wrapped.
         if (filled) begin
            win_sum -= longint'(ring[wr_idx]);
            if (ring_bad[wr_idx]) bad_count--;
         end
         ring[wr_idx] = ua[15:0];
         ring_bad[wr_idx] = !code_ok;
         win_sum += ua;
         if (!code_ok) bad_count++;
         if (wr_idx == WINDOW - 1) begin
            wr_idx = 0;
            filled = 1'b1;
         end else begin
            wr_idx++;
         end
         last_ua = ua[15:0];
         last_ok = code_ok;
      end

      fill = filled ? WINDOW : wr_idx;
      avg = 0;
      pres = 0;
      mean_ok = (fill != 0) && (bad_count == 0);
      if (mean_ok) begin
         avg = (win_sum + fill / 2) / fill;
         num = longint'(loop_cfg.cal_scale_q16) * (win_sum - LOOP_ZERO_UA * fill);
         den = fill * 65536;
         // Exact quotient, rounded half away from zero.
         pres = (num >= 0) ? (num + den / 2) / den : -((den / 2 - num) / den);
         pres += longint'(loop_cfg.cal_offset_pa);
         if (pres > PRES_MAX) pres = PRES_MAX;
         if (pres < PRES_MIN) pres = PRES_MIN;
      end
      loop_ok = last_ok && (last_ua >= loop_cfg.loop_break_ua);

      if (item.operation == OP_CHECK) begin
         if (!loop_ok) begin
            latched = 1'b0;
            pending = 1'b0;
            start_ms = '0;
         end else if (mean_ok && pres > longint'(loop_cfg.alarm_threshold_pa)) begin
            if (!pending) begin
               pending = 1'b1;
               start_ms = item.now_ms;
            end
            held = item.now_ms - start_ms;
            if (held >= loop_cfg.alarm_hold_ms) latched = 1'b1;
         end else begin
            pending = 1'b0;
            start_ms = '0;
         end
      end else if (item.operation == OP_CLEAR) begin
         latched = 1'b0;
         pending = 1'b0;
         start_ms = '0;
      end

      reading.current_ua    = last_ua;
      reading.current_valid = last_ok;
      reading.average_ua    = avg[15:0];
      reading.average_valid = mean_ok;
      reading.pressure_pa   = pres[15:0];
      reading.sensor_ok     = loop_ok;
      reading.alarm_latched = latched;
      return reading;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         REG_MAX_CODE:  loop_cfg.max_code           = value[14:0];
         REG_UA_Q16:    loop_cfg.ua_per_code_q16    = value[19:0];
         REG_LOOP_BRK:  loop_cfg.loop_break_ua      = value[14:0];
         REG_CAL_OFS:   loop_cfg.cal_offset_pa      = value[15:0];
         REG_CAL_SCALE: loop_cfg.cal_scale_q16      = value;
         REG_ALARM_THR: loop_cfg.alarm_threshold_pa = value[15:0];
         REG_HOLD_MS:   loop_cfg.alarm_hold_ms      = value;
         default: ;
      endcase
   endtask

   // A gap of zero keeps valid high so the next item follows back to back.
   task automatic send_item(input req_type item, input int gap, input bit fixed,
                            input rsp_type fixed_reading);
      rsp_type reading;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      reading = predict_reading(item);
      readings_due.push_back(fixed ? fixed_reading : reading);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Bursts of samples around a level, then a run of checks with time moving
   // forward, with clears and stray items mixed in.
   task automatic run_readings(input int quota);
      int          sent, level, r;
      logic [31:0] step;
      req_type     item;
      sent = 0;
      while (sent < quota) begin
         level = $urandom_range(0, loop_cfg.max_code);
         repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(0, 99);
            item.operation = OP_SAMPLE;
            if (r < 3)
               item.adc_code = 16'(-$urandom_range(1, 32768));
            else if (r < 5)
               item.adc_code = 16'($urandom);
            else if (r < 7 && loop_cfg.max_code != 15'h7FFF)
               item.adc_code = 16'($urandom_range(loop_cfg.max_code + 1, 32767));
            else
               item.adc_code = 16'(level + $urandom_range(0, 200) - 100);
            item.now_ms = $urandom;
            send_item(item, pick_gap(), 1'b0, '0);
            sent++;
         end
         repeat ($urandom_range(1, 5)) begin
            r = $urandom_range(0, 99);
            if (r < 15)
               step = loop_cfg.alarm_hold_ms;
            else if (r < 20)
               step = loop_cfg.alarm_hold_ms - 1;
            else if (r < 28)
               step = $urandom;
            else
               step = $urandom_range(0, (loop_cfg.alarm_hold_ms > 300000) ?
                                        100000 : loop_cfg.alarm_hold_ms / 3 + 1);
            tick_ms += step;
            item.operation = OP_CHECK;
            item.adc_code  = 16'($urandom);
            item.now_ms    = tick_ms;
            send_item(item, pick_gap(), 1'b0, '0);
            sent++;
         end
         r = $urandom_range(0, 99);
         if (r < 25) begin
            item.operation = (r < 10) ? OP_CLEAR : 2'($urandom_range(0, 3));
            item.adc_code  = 16'($urandom);
            item.now_ms    = $urandom;
            send_item(item, pick_gap(), 1'b0, '0);
            if (item.operation != OP_UNUSED) sent++;
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: compare each transfer, then decide the next cycle's ready.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (readings_due.size() == 0) begin
            $error("reading arrived with none outstanding");
            fault_count++;
         end else begin
            want = readings_due.pop_front();
            check_field("current_ua", want.current_ua, rsp_data.current_ua);
            check_field("current_valid", want.current_valid, rsp_data.current_valid);
            check_field("average_ua", want.average_ua, rsp_data.average_ua);
            check_field("average_valid", want.average_valid, rsp_data.average_valid);
            check_field("pressure_pa", want.pressure_pa, rsp_data.pressure_pa);
            check_field("sensor_ok", want.sensor_ok, rsp_data.sensor_ok);
            check_field("alarm_latched", want.alarm_latched, rsp_data.alarm_latched);
         end
      end
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] reg_val [N_REGS];
      logic [31:0] scale;
      loop_cfg = '{max_code: 15'd32767, ua_per_code_q16: 20'd49648,
                   loop_break_ua: 15'd3500, cal_offset_pa: 16'sd0,
                   cal_scale_q16: 32'sd65536, alarm_threshold_pa: 16'sd200,
                   alarm_hold_ms: 32'd60000};
      tick_ms = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < N_STEPS; k++)
         send_item(directed_plan[k].item, (k == N_STEPS - 1) ? 1 + pick_gap() : pick_gap(),
                   directed_plan[k].fixed, directed_plan[k].reading);

      for (int p = 0; p < N_PHASES; p++) begin
         // Registers change only with the block drained.
         while (readings_due.size() != 0) @(posedge clock);
         if (p == 0) begin
            reg_val[REG_MAX_CODE]  = 32'h7FFF;
            reg_val[REG_UA_Q16]    = 32'hF_FFFF;
            reg_val[REG_LOOP_BRK]  = 32'h0;
            reg_val[REG_CAL_OFS]   = 32'h7FFF;
            reg_val[REG_CAL_SCALE] = 32'h7FFF_FFFF;
            reg_val[REG_ALARM_THR] = 32'hFFFF_8000;
            reg_val[REG_HOLD_MS]   = 32'h0;
         end else if (p == 1) begin
            reg_val[REG_MAX_CODE]  = 32'h0;
            reg_val[REG_UA_Q16]    = 32'h0;
            reg_val[REG_LOOP_BRK]  = 32'h7FFF;
            reg_val[REG_CAL_OFS]   = 32'hFFFF_8000;
            reg_val[REG_CAL_SCALE] = 32'h8000_0000;
            reg_val[REG_ALARM_THR] = 32'h7FFF;
            reg_val[REG_HOLD_MS]   = 32'hFFFF_FFFF;
         end else if (p % 2 == 0) begin
            reg_val[REG_MAX_CODE]  = $urandom_range(20000, 32767);
            reg_val[REG_UA_Q16]    = $urandom_range(30000, 70000);
            reg_val[REG_LOOP_BRK]  = $urandom_range(2000, 4500);
            reg_val[REG_CAL_OFS]   = $urandom_range(0, 4000) - 2000;
            scale = $urandom_range(0, 4 * 65536);
            if ($urandom_range(0, 3) == 0) scale = -scale;
            reg_val[REG_CAL_SCALE] = scale;
            reg_val[REG_ALARM_THR] = $urandom_range(0, 16000);
            reg_val[REG_HOLD_MS]   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5000);
         end else begin
            for (int k = 0; k < N_REGS; k++) reg_val[k] = $urandom;
         end
         for (int k = 0; k < N_REGS; k++) write_reg(REG_IDX_W'(k), reg_val[k]);
         // Goes last so an address that aliases a real register shows up.
         write_reg(REG_UNUSED, $urandom);

         quiet = (p == 4) || (p == 8);
         if (p == 3) hold_off_request = 1'b1;
         run_readings(PHASE_ITEMS);
      end

      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
